/* hw/rtl/lru_page_replacement_defines.svh */
// Assertion macros shared by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked on clk, masked during rst.
`define LRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, masked during rst.
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/lru_pkg.sv */
// Types and constants for the LRU page replacement block.
package lru_pkg;

  localparam int PAGE_W  = 16;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map: index taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX           = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } lru_state_t;

endpackage

/* hw/rtl/lru_req_if.sv */
// Request channel: one page reference word.
interface lru_req_if;
  logic                       valid;
  logic                       ready;
  logic [lru_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

/* hw/rtl/lru_rsp_if.sv */
// Response channel: one replacement result word.
interface lru_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lru_pkg::SLOT_W-1:0] frame_slot;
  logic                       evicted;
  logic [lru_pkg::PAGE_W-1:0] evicted_page;
  logic [lru_pkg::CNT_W-1:0]  fault_total;
  logic [lru_pkg::CNT_W-1:0]  hit_total;

  modport source (output valid, output hit, output frame_slot, output evicted,
                  output evicted_page, output fault_total, output hit_total,
                  input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted,
                  input evicted_page, input fault_total, input hit_total,
                  output ready);
endinterface

/* hw/rtl/lru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lru_page_replacement.sv */
// LRU page replacement: top level with frame scan sequencer and APB register.
// A word is accepted in ST_IDLE, and its n active frames are scanned in ST_SCAN
// (n = frames_in_use clamped to 1..FRAMES; one frame is read and compared per cycle);
// ST_FIN then commits it and loads the output register once that register is free.
// No new word is accepted until the last one has left ST_FIN.
// Reset (rst, synchronous): all frames empty, clock and counts zero,
// frames_in_use = 16; no clearing pass is needed.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
  parameter int FRAMES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  lru_req_if.sink                     req,
  lru_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lru_pkg::PADDR_W-1:0] paddr,
  input  logic [lru_pkg::PDATA_W-1:0] pwdata,
  output logic [lru_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  lru_pkg::lru_state_t state, state_next;

  logic [lru_pkg::CFG_W-1:0]   frames_in_use;
  logic [CW-1:0]               n_act;
  logic [FRAMES-1:0]           slot_valid;
  logic [lru_pkg::STAMP_W-1:0] access_clock;
  logic [lru_pkg::CNT_W-1:0]   fault_count;
  logic [lru_pkg::CNT_W-1:0]   hit_count;

  logic [lru_pkg::PAGE_W-1:0]  req_page;
  logic [CW-1:0]               rd_idx;
  logic [IW-1:0]               cmp_idx;
  logic                        cmp_vld;

  logic                        hit_found;
  logic [IW-1:0]               hit_slot;
  logic                        empty_found;
  logic [IW-1:0]               empty_slot;
  logic                        min_set;
  logic [IW-1:0]               min_slot;
  logic [lru_pkg::STAMP_W-1:0] min_stamp;
  logic [lru_pkg::PAGE_W-1:0]  min_page;

  logic [lru_pkg::PAGE_W-1:0]  rd_page;
  logic [lru_pkg::STAMP_W-1:0] rd_stamp;

  logic                        issue;
  logic                        scan_done;
  logic                        fin_go;
  logic [IW-1:0]               sel_slot;
  logic [31:0]                 sel_slot_w;
  logic                        cmp_valid_bit;
  logic                        cfg_wr;

  logic                        out_valid;
  logic                        out_hit;
  logic [lru_pkg::SLOT_W-1:0]  out_slot;
  logic                        out_evicted;
  logic [lru_pkg::PAGE_W-1:0]  out_evicted_page;
  logic [lru_pkg::CNT_W-1:0]   fault_total_next;
  logic [lru_pkg::CNT_W-1:0]   hit_total_next;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == lru_pkg::REG_FRAMES_IN_USE) ?
                  {{(lru_pkg::PDATA_W-lru_pkg::CFG_W){1'b0}}, frames_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_wr && paddr[2] == lru_pkg::REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[lru_pkg::CFG_W-1:0];
    end
  end

  // Clamp frame count to 1..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_act = CW'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(frames_in_use);
    end
  end

  // Frame page and stamp stores
  lru_ram #(.WIDTH(lru_pkg::PAGE_W), .DEPTH(FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (state == lru_pkg::ST_FIN && fin_go && !hit_found),
    .waddr (sel_slot),
    .wdata (req_page),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rd_page)
  );

  lru_ram #(.WIDTH(lru_pkg::STAMP_W), .DEPTH(FRAMES)) u_stamp_ram (
    .clk   (clk),
    .we    (state == lru_pkg::ST_FIN && fin_go),
    .waddr (sel_slot),
    .wdata (access_clock + 1'b1),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rd_stamp)
  );

  // Sequencer control
  assign issue     = (state == lru_pkg::ST_SCAN) && (rd_idx < n_act);
  assign scan_done = (state == lru_pkg::ST_SCAN) && (rd_idx == n_act) && !cmp_vld;
  assign fin_go    = !out_valid || rsp.ready;
  assign req.ready = (state == lru_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      lru_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = lru_pkg::ST_SCAN;
        end
      end
      lru_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = lru_pkg::ST_FIN;
        end
      end
      lru_pkg::ST_FIN: begin
        if (fin_go) begin
          state_next = lru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance read index and compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (req.valid && req.ready) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= rd_idx[IW-1:0];
    end
    if (req.valid && req.ready) begin
      req_page <= req.page_number;
    end
  end

  assign cmp_valid_bit = slot_valid[cmp_idx];

  // Shared compare step: match, first empty, least recent stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      min_set     <= 1'b0;
    end else if (req.valid && req.ready) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      min_set     <= 1'b0;
    end else if (cmp_vld) begin
      if (cmp_valid_bit && rd_page == req_page && !hit_found) begin
        hit_found <= 1'b1;
      end
      if (!cmp_valid_bit && !empty_found) begin
        empty_found <= 1'b1;
      end
      if (cmp_valid_bit && (!min_set || rd_stamp < min_stamp)) begin
        min_set <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld) begin
      if (cmp_valid_bit && rd_page == req_page && !hit_found) begin
        hit_slot <= cmp_idx;
      end
      if (!cmp_valid_bit && !empty_found) begin
        empty_slot <= cmp_idx;
      end
      if (cmp_valid_bit && (!min_set || rd_stamp < min_stamp)) begin
        min_slot  <= cmp_idx;
        min_stamp <= rd_stamp;
        min_page  <= rd_page;
      end
    end
  end

  // Pick the frame for this reference
  always_comb begin
    if (hit_found) begin
      sel_slot = hit_slot;
    end else if (empty_found) begin
      sel_slot = empty_slot;
    end else begin
      sel_slot = min_slot;
    end
  end

  assign sel_slot_w       = 32'(sel_slot);
  assign fault_total_next = (!hit_found && fault_count != lru_pkg::CNT_MAX) ?
                            fault_count + 1'b1 : fault_count;
  assign hit_total_next   = (hit_found && hit_count != lru_pkg::CNT_MAX) ?
                            hit_count + 1'b1 : hit_count;

  // Commit frame state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      access_clock <= '0;
      fault_count  <= '0;
      hit_count    <= '0;
    end else if (state == lru_pkg::ST_FIN && fin_go) begin
      access_clock <= access_clock + 1'b1;
      fault_count  <= fault_total_next;
      hit_count    <= hit_total_next;
      if (!hit_found) begin
        slot_valid[sel_slot] <= 1'b1;
      end
    end
  end

  // Output register: hold result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lru_pkg::ST_FIN && fin_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lru_pkg::ST_FIN && fin_go) begin
      out_hit          <= hit_found;
      out_slot         <= sel_slot_w[lru_pkg::SLOT_W-1:0];
      out_evicted      <= !hit_found && !empty_found;
      out_evicted_page <= (!hit_found && !empty_found) ? min_page : '0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.frame_slot   = out_slot;
  assign rsp.evicted      = out_evicted;
  assign rsp.evicted_page = out_evicted_page;
  assign rsp.fault_total  = fault_count;
  assign rsp.hit_total    = hit_count;

  // Checks
  `LRU_ASSERT_NEXT(a_accept_starts_scan, req.valid && req.ready, state == lru_pkg::ST_SCAN, "accepted word did not start a scan")
  `LRU_ASSERT_NEXT(a_fin_loads_output, state == lru_pkg::ST_FIN && fin_go, rsp.valid, "finished word not presented")
  `LRU_ASSERT_NOW(a_evict_needs_miss, out_valid && out_evicted, !out_hit, "eviction reported on a hit")
  `LRU_ASSERT_NEXT(a_counts_monotonic, 1'b1, fault_count >= $past(fault_count) && hit_count >= $past(hit_count), "counter decreased")

endmodule
